[hw/rtl/pts_pkg.sv]
// Shared types, constants and byte-class functions of the text pre-tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  localparam int LookaheadDepth = 16;
  localparam int IdxW           = $clog2(LookaheadDepth);
  localparam int CountW         = $clog2(LookaheadDepth + 1);

  localparam int StartLen = 15;
  localparam int EndLen   = 13;
  localparam int EmitW    = 4;

  // Special words, already in lower case.
  localparam logic [7:0] WordStart [StartLen] = '{
    8'h3C, 8'h7C, 8'h73, 8'h74, 8'h61, 8'h72, 8'h74, 8'h6F,
    8'h66, 8'h74, 8'h65, 8'h78, 8'h74, 8'h7C, 8'h3E
  };
  localparam logic [7:0] WordEnd [EndLen] = '{
    8'h3C, 8'h7C, 8'h65, 8'h6E, 8'h64, 8'h6F, 8'h66, 8'h74,
    8'h65, 8'h78, 8'h74, 8'h7C, 8'h3E
  };

  localparam logic [7:0] CharApos = 8'h27;
  localparam logic [7:0] CharS    = 8'h73;
  localparam logic [7:0] CharT    = 8'h74;
  localparam logic [7:0] CharM    = 8'h6D;
  localparam logic [7:0] CharD    = 8'h64;
  localparam logic [7:0] CharR    = 8'h72;
  localparam logic [7:0] CharV    = 8'h76;
  localparam logic [7:0] CharL    = 8'h6C;
  localparam logic [7:0] CharE    = 8'h65;

  typedef enum logic [1:0] {
    RC_NONE   = 2'd0,
    RC_LETTER = 2'd1,
    RC_OTHER  = 2'd2
  } run_class_e;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } pts_cmd_t;

  typedef struct packed {
    logic put;
    logic done;
    logic hold_valid;
    logic out_free;
  } pts_status_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0D) || (c == 8'h0C) || (c == 8'h0B);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || c[7];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pts_ctrl.sv]
// Controller of the text pre-tokenizer: sequences load, settle steps and the final flush.
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       s_valid_i,
  output logic                      s_ready_o,
  input  wire pts_pkg::pts_status_t status_i,
  output pts_pkg::pts_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SETTLE = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SETTLE;
        end
      end
      S_SETTLE: begin
        if (status_i.done) begin
          // The held result is the last one of this item and leaves with run_last set.
          if (!status_i.hold_valid) begin
            state_d = S_IDLE;
          end else if (status_i.out_free) begin
            cmd_o.flush = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (!(status_i.put && status_i.hold_valid && !status_i.out_free)) begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !status_i.hold_valid)
    else $error("result still held while idle");

  a_flush_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush |=> (state_q == S_IDLE) && !status_i.hold_valid)
    else $error("flush did not end the item");

  a_no_step_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !cmd_o.step && !cmd_o.flush)
    else $error("settle command while idle");

endmodule

`default_nettype wire

[hw/rtl/pts_datapath.sv]
// Datapath of the text pre-tokenizer: lookahead store, rule decision, held and output results.
`timescale 1ns / 1ps
`default_nettype none

module pts_datapath (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire  [7:0]                in_byte_i,
  input  wire                       in_end_i,
  input  wire pts_pkg::pts_cmd_t    cmd_i,
  output pts_pkg::pts_status_t      status_o,
  output logic [7:0]                out_byte_o,
  output logic                      out_token_end_o,
  output logic                      out_special_o,
  output logic                      out_text_done_o,
  output logic                      out_run_last_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i
);

  typedef enum logic [1:0] {
    A_DONE   = 2'd0,
    A_PUT    = 2'd1,
    A_SET_RC = 2'd2,
    A_EMIT   = 2'd3
  } action_e;

  // Lookahead store and its fill count.
  logic [7:0]                  store_q [pts_pkg::LookaheadDepth];
  logic [pts_pkg::CountW-1:0]  cnt_q, cnt_d;
  pts_pkg::run_class_e         rc_q, rc_d;
  logic [pts_pkg::EmitW-1:0]   emit_cnt_q, emit_cnt_d;
  logic                        emit_sp_q;
  logic                        closed_q;
  logic                        last_q;

  // Result waiting until it is known whether it is the last of the item.
  logic                        hold_valid_q, hold_valid_d;
  logic [7:0]                  hold_byte_q;
  logic                        hold_end_q;
  logic                        hold_sp_q;

  logic                        out_valid_q, out_valid_d;
  logic                        out_free;

  // Decision outputs.
  action_e                     act;
  logic                        put_end;
  logic                        put_sp;
  pts_pkg::run_class_e         rc_new;
  logic [pts_pkg::EmitW-1:0]   emit_k;
  logic                        emit_sp_new;

  logic [7:0]                  s0, s1, s2;
  logic [pts_pkg::StartLen-1:0] ok_start;
  logic [pts_pkg::EndLen-1:0]   ok_end;
  logic                        start_full, start_pend, end_full, end_pend;
  logic                        fits;
  logic                        apos_wait;
  logic [pts_pkg::EmitW-1:0]   apos_k;
  logic                        in_ws;
  logic                        do_put;

  assign s0 = store_q[0];
  assign s1 = store_q[1];
  assign s2 = store_q[2];

  // Entries at or beyond the fill count do not take part in a word match.
  always_comb begin
    for (int i = 0; i < pts_pkg::StartLen; i++) begin
      ok_start[i] = (store_q[i] == pts_pkg::WordStart[i]) ||
                    (pts_pkg::CountW'(i) >= cnt_q);
    end
    for (int i = 0; i < pts_pkg::EndLen; i++) begin
      ok_end[i] = (store_q[i] == pts_pkg::WordEnd[i]) ||
                  (pts_pkg::CountW'(i) >= cnt_q);
    end
  end

  assign start_full = (&ok_start) && (cnt_q >= pts_pkg::CountW'(pts_pkg::StartLen));
  assign start_pend = (&ok_start) && (cnt_q <  pts_pkg::CountW'(pts_pkg::StartLen));
  assign end_full   = (&ok_end)   && (cnt_q >= pts_pkg::CountW'(pts_pkg::EndLen));
  assign end_pend   = (&ok_end)   && (cnt_q <  pts_pkg::CountW'(pts_pkg::EndLen));

  assign fits = (rc_q == pts_pkg::RC_LETTER) ? pts_pkg::is_letter(s1) :
                (!pts_pkg::is_letter(s1) && !pts_pkg::is_digit(s1));

  // Contraction check on an apostrophe at the head of the store.
  always_comb begin
    apos_wait = 1'b0;
    apos_k    = '0;
    if (cnt_q >= pts_pkg::CountW'(2)) begin
      if ((s1 == pts_pkg::CharS) || (s1 == pts_pkg::CharT) ||
          (s1 == pts_pkg::CharM) || (s1 == pts_pkg::CharD)) begin
        apos_k = pts_pkg::EmitW'(2);
      end else if ((s1 == pts_pkg::CharR) || (s1 == pts_pkg::CharV) ||
                   (s1 == pts_pkg::CharL)) begin
        if (cnt_q >= pts_pkg::CountW'(3)) begin
          if (((s1 == pts_pkg::CharL) && (s2 == pts_pkg::CharL)) ||
              ((s1 != pts_pkg::CharL) && (s2 == pts_pkg::CharE))) begin
            apos_k = pts_pkg::EmitW'(3);
          end
        end else if (!closed_q) begin
          apos_wait = 1'b1;
        end
      end
    end else if (!closed_q) begin
      apos_wait = 1'b1;
    end
  end

  // One rule step of the settle loop per cycle, unless a stalled output holds the step back.
  always_comb begin
    act         = A_DONE;
    put_end     = 1'b0;
    put_sp      = 1'b0;
    rc_new      = rc_q;
    emit_k      = '0;
    emit_sp_new = 1'b0;
    priority if (emit_cnt_q != '0) begin
      act     = A_PUT;
      put_end = (emit_cnt_q == pts_pkg::EmitW'(1));
      put_sp  = emit_sp_q;
    end else if (rc_q != pts_pkg::RC_NONE) begin
      priority if (cnt_q == '0) begin
        act    = A_SET_RC;
        rc_new = pts_pkg::RC_NONE;
      end else if (cnt_q >= pts_pkg::CountW'(2)) begin
        act     = A_PUT;
        put_end = !fits;
        rc_new  = fits ? rc_q : pts_pkg::RC_NONE;
      end else if (closed_q) begin
        act     = A_PUT;
        put_end = 1'b1;
        rc_new  = pts_pkg::RC_NONE;
      end else begin
        act = A_DONE;
      end
    end else if (cnt_q == '0) begin
      act = A_DONE;
    end else if (start_full) begin
      act         = A_EMIT;
      emit_k      = pts_pkg::EmitW'(pts_pkg::StartLen);
      emit_sp_new = 1'b1;
    end else if (end_full) begin
      act         = A_EMIT;
      emit_k      = pts_pkg::EmitW'(pts_pkg::EndLen);
      emit_sp_new = 1'b1;
    end else if ((start_pend || end_pend) && !closed_q) begin
      act = A_DONE;
    end else if ((s0 == pts_pkg::CharApos) && apos_wait) begin
      act = A_DONE;
    end else if ((s0 == pts_pkg::CharApos) && (apos_k != '0)) begin
      act    = A_EMIT;
      emit_k = apos_k;
    end else if (pts_pkg::is_letter(s0)) begin
      act    = A_SET_RC;
      rc_new = pts_pkg::RC_LETTER;
    end else if (pts_pkg::is_digit(s0)) begin
      act     = A_PUT;
      put_end = 1'b1;
    end else begin
      act    = A_SET_RC;
      rc_new = pts_pkg::RC_OTHER;
    end
  end

  assign in_ws    = pts_pkg::is_ws(in_byte_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign do_put   = cmd_i.step && (act == A_PUT);

  always_comb begin
    cnt_d        = cnt_q;
    rc_d         = rc_q;
    emit_cnt_d   = emit_cnt_q;
    hold_valid_d = hold_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      if (!in_ws && (cnt_q < pts_pkg::CountW'(pts_pkg::LookaheadDepth))) begin
        cnt_d = cnt_q + pts_pkg::CountW'(1);
      end
    end else if (cmd_i.step) begin
      unique case (act)
        A_PUT: begin
          cnt_d        = cnt_q - pts_pkg::CountW'(1);
          rc_d         = rc_new;
          hold_valid_d = 1'b1;
          if (emit_cnt_q != '0) begin
            emit_cnt_d = emit_cnt_q - pts_pkg::EmitW'(1);
          end
          if (hold_valid_q) begin
            out_valid_d = 1'b1;
          end
        end
        A_SET_RC: rc_d = rc_new;
        A_EMIT:   emit_cnt_d = emit_k;
        A_DONE:   ;
        default:  ;
      endcase
    end else if (cmd_i.flush) begin
      hold_valid_d = 1'b0;
      out_valid_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      rc_q         <= pts_pkg::RC_NONE;
      emit_cnt_q   <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      rc_q         <= rc_d;
      emit_cnt_q   <= emit_cnt_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Store: append at the fill count on load of a non-whitespace byte, shift down by one on every result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (!in_ws && (cnt_q < pts_pkg::CountW'(pts_pkg::LookaheadDepth))) begin
        store_q[cnt_q[pts_pkg::IdxW-1:0]] <= pts_pkg::to_lower(in_byte_i);
      end
    end else if (do_put) begin
      for (int i = 0; i < pts_pkg::LookaheadDepth - 1; i++) begin
        store_q[i] <= store_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      closed_q <= in_ws || in_end_i;
      last_q   <= in_end_i;
    end
    if (cmd_i.step && (act == A_EMIT)) begin
      emit_sp_q <= emit_sp_new;
    end
    if (do_put) begin
      hold_byte_q <= s0;
      hold_end_q  <= put_end;
      hold_sp_q   <= put_sp;
    end
    if ((do_put && hold_valid_q) || cmd_i.flush) begin
      out_byte_o      <= hold_byte_q;
      out_token_end_o <= hold_end_q;
      out_special_o   <= hold_sp_q;
      out_run_last_o  <= cmd_i.flush;
      out_text_done_o <= cmd_i.flush && last_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.put        = (act == A_PUT);
  assign status_o.done       = (act == A_DONE);
  assign status_o.hold_valid = hold_valid_q;
  assign status_o.out_free   = out_free;

  a_store_room_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (cnt_q < pts_pkg::CountW'(pts_pkg::LookaheadDepth)))
    else $error("lookahead store full when an item arrived");

  a_emit_within_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_cnt_q != '0) |-> (cnt_q >= pts_pkg::CountW'(emit_cnt_q)))
    else $error("token emit runs past the stored bytes");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((do_put && hold_valid_q) || cmd_i.flush) |-> out_free)
    else $error("output register overwritten while stalled");

  a_put_shrinks_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_put |=> (cnt_q == $past(cnt_q) - pts_pkg::CountW'(1)) && hold_valid_q)
    else $error("result step did not consume a stored byte");

endmodule

`default_nettype wire

[hw/rtl/text_pretokenizer_splitter.sv]
// Top level of the text pre-tokenizer: splits a byte stream into lowercased pre-tokens.
//
// The text enters on the slave stream, one raw byte per item, with tlast on the
// final byte. Tokens leave on the master stream, one byte per item: tlast marks the
// last byte of a token, tuser flags special words, the end of the text and the last
// result caused by each input item. Whitespace bytes produce no output.
// Each input item is loaded and then settled by steps of the rule sequencer (one step
// per emitted byte and one per run or token decision); a final flush hands over the
// held result, if there is one. A new item is taken only once the previous one is
// settled.
// Each result waits in a holding register until the next result of the same item
// is decided or the item ends, and then moves to the output register.
// An item is taken while the last result of the previous item still waits in the
// output register; a stalled receiver holds the output register and, when a
// further result is due, stops the sequencer until the output is taken.
// After reset the lookahead store is empty, no token is open and the block is
// ready at once.
`timescale 1ns / 1ps
`default_nettype none

module text_pretokenizer_splitter (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,  // [7:0] text_byte
  input  wire         s_axis_tlast,  // text_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] token_byte
  output logic        m_axis_tlast,  // token_end
  output logic [2:0]  m_axis_tuser   // [0] special_word, [1] text_done, [2] run_last
);

  pts_pkg::pts_cmd_t    cmd;
  pts_pkg::pts_status_t status;

  pts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pts_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_byte_i       (s_axis_tdata),
    .in_end_i        (s_axis_tlast),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_byte_o      (m_axis_tdata),
    .out_token_end_o (m_axis_tlast),
    .out_special_o   (m_axis_tuser[0]),
    .out_text_done_o (m_axis_tuser[1]),
    .out_run_last_o  (m_axis_tuser[2]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready)
  );

endmodule

`default_nettype wire
